[sv/ssc_pkg.sv]
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants and types for the stack sequence checker.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int DEPTH       = 128;
  localparam int SYMBOL_BITS = 8;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS    = $clog2(DEPTH + 1);
  localparam int OP_BITS     = 2;

  typedef logic [OP_BITS-1:0]     op_t;
  typedef logic [SYMBOL_BITS-1:0] sym_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_RUN  = 2'd2;

  localparam cnt_t CNT_DEPTH = cnt_t'(DEPTH);

endpackage

[sv/ssc_ram.sv]
// ----------------------------------------------------------------------------
// ssc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/stack_sequence_checker.sv]
// ----------------------------------------------------------------------------
// stack_sequence_checker
// Checks whether a pop sequence can be produced from a push sequence
// through one last-in first-out stack.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the op (load push symbol, load pop symbol,
// run check), tdata the symbol. A load into a full store is dropped and
// flagged. A run produces exactly one output transaction holding
// valid_res, count_mismatch and overflowed, then clears both counts and
// the overflow flag.
// A run with differing or zero counts answers in the next cycle. Otherwise
// the walk uses the push, pop and stack RAMs (registered read each): each
// pop steps through ST_CMP and ST_LATCH, each push through ST_CMP and
// ST_PUSH, and no input is taken until the result is presented.
// Input is also held off while a result waits in the output register and
// the receiver stalls; the result stays until taken.
// Reset clears counts, flags and the output valid; RAM contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module stack_sequence_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] symbol
  input  logic [1:0] s_tuser,  // [1:0] op
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata   // [0] valid_res, [1] count_mismatch, [2] overflowed
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LATCH = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]    state;
  ssc_pkg::cnt_t push_count;
  ssc_pkg::cnt_t pop_count;
  logic          load_overflow;
  ssc_pkg::cnt_t next_push;
  ssc_pkg::cnt_t next_pop;
  ssc_pkg::cnt_t height;
  ssc_pkg::sym_t top;
  ssc_pkg::sym_t pop_sym;
  logic          res_valid;
  logic          res_mismatch;
  logic          res_overflow;

  logic          in_fire;
  logic          run_now;
  ssc_pkg::sym_t in_sym;
  logic          push_we;
  logic          pop_we;
  logic          stack_we;
  ssc_pkg::cnt_t next_pop_inc;
  ssc_pkg::cnt_t height_m2;
  logic          match;
  ssc_pkg::addr_t pop_raddr;
  ssc_pkg::sym_t push_rdata;
  ssc_pkg::sym_t pop_rdata;
  ssc_pkg::sym_t stack_rdata;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign m_tdata  = {5'd0, res_overflow, res_mismatch, res_valid};

  always_comb begin
    in_fire      = s_tvalid && s_tready;
    run_now      = in_fire && (s_tuser == ssc_pkg::OP_RUN) &&
                   (push_count != pop_count || push_count == '0);
    in_sym       = s_tdata[ssc_pkg::SYMBOL_BITS-1:0];
    push_we      = in_fire && (s_tuser == ssc_pkg::OP_PUSH) &&
                   (push_count < ssc_pkg::CNT_DEPTH);
    pop_we       = in_fire && (s_tuser == ssc_pkg::OP_POP) &&
                   (pop_count < ssc_pkg::CNT_DEPTH);
    stack_we     = (state == ST_PUSH);
    next_pop_inc = next_pop + ssc_pkg::cnt_t'(1);
    height_m2    = height - ssc_pkg::cnt_t'(2);
    match        = (height != '0) && (top == pop_sym);
    if (state == ST_IDLE) begin
      pop_raddr = '0;
    end else if (state == ST_CMP && match) begin
      pop_raddr = next_pop_inc[ssc_pkg::ADDR_BITS-1:0];
    end else begin
      pop_raddr = next_pop[ssc_pkg::ADDR_BITS-1:0];
    end
  end

  ssc_ram #(.WIDTH(ssc_pkg::SYMBOL_BITS), .DEPTH(ssc_pkg::DEPTH)) u_push_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (push_count[ssc_pkg::ADDR_BITS-1:0]),
    .wdata (in_sym),
    .raddr (next_push[ssc_pkg::ADDR_BITS-1:0]),
    .rdata (push_rdata)
  );

  ssc_ram #(.WIDTH(ssc_pkg::SYMBOL_BITS), .DEPTH(ssc_pkg::DEPTH)) u_pop_ram (
    .clk   (clk),
    .we    (pop_we),
    .waddr (pop_count[ssc_pkg::ADDR_BITS-1:0]),
    .wdata (in_sym),
    .raddr (pop_raddr),
    .rdata (pop_rdata)
  );

  ssc_ram #(.WIDTH(ssc_pkg::SYMBOL_BITS), .DEPTH(ssc_pkg::DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (height[ssc_pkg::ADDR_BITS-1:0]),
    .wdata (push_rdata),
    .raddr (height_m2[ssc_pkg::ADDR_BITS-1:0]),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      push_count    <= '0;
      pop_count     <= '0;
      load_overflow <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !run_now) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (s_tuser)
              ssc_pkg::OP_PUSH: begin
                if (push_we) begin
                  push_count <= push_count + ssc_pkg::cnt_t'(1);
                end else begin
                  load_overflow <= 1'b1;
                end
              end
              ssc_pkg::OP_POP: begin
                if (pop_we) begin
                  pop_count <= pop_count + ssc_pkg::cnt_t'(1);
                end else begin
                  load_overflow <= 1'b1;
                end
              end
              ssc_pkg::OP_RUN: begin
                if (run_now) begin
                  m_tvalid      <= 1'b1;
                  res_valid     <= (push_count == pop_count);
                  res_mismatch  <= (push_count != pop_count);
                  res_overflow  <= load_overflow;
                  push_count    <= '0;
                  pop_count     <= '0;
                  load_overflow <= 1'b0;
                end else begin
                  next_push <= '0;
                  next_pop  <= '0;
                  height    <= '0;
                  state     <= ST_LATCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_LATCH: begin
          pop_sym <= pop_rdata;
          top     <= stack_rdata;
          state   <= ST_CMP;
        end
        ST_CMP: begin
          if (match) begin
            height   <= height - ssc_pkg::cnt_t'(1);
            next_pop <= next_pop_inc;
            if (next_pop_inc == push_count) begin
              m_tvalid      <= 1'b1;
              res_valid     <= 1'b1;
              res_mismatch  <= 1'b0;
              res_overflow  <= load_overflow;
              push_count    <= '0;
              pop_count     <= '0;
              load_overflow <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              state <= ST_LATCH;
            end
          end else if (next_push == push_count) begin
            m_tvalid      <= 1'b1;
            res_valid     <= 1'b0;
            res_mismatch  <= 1'b0;
            res_overflow  <= load_overflow;
            push_count    <= '0;
            pop_count     <= '0;
            load_overflow <= 1'b0;
            state         <= ST_IDLE;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          top       <= push_rdata;
          height    <= height + ssc_pkg::cnt_t'(1);
          next_push <= next_push + ssc_pkg::cnt_t'(1);
          state     <= ST_CMP;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
